### rtl/dpfm_pkg.sv
// ----------------------------------------------------------------------------
// dpfm_pkg
// Shared types and codes of the demand paging frame manager.
// ----------------------------------------------------------------------------
package dpfm_pkg;

  localparam int NUM_FRAMES_DEF       = 64;
  localparam int NUM_PROCS_DEF        = 16;
  localparam int VIRT_LIMIT_BYTES_DEF = 65536;
  localparam int MAX_ACCESS_BYTES_DEF = 64;

  // request codes
  localparam logic [2:0] REQ_REGISTER  = 3'd0;
  localparam logic [2:0] REQ_ACCESS    = 3'd1;
  localparam logic [2:0] REQ_TRANSLATE = 3'd2;
  localparam logic [2:0] REQ_RELEASE   = 3'd3;
  localparam logic [2:0] REQ_CLEAR     = 3'd4;

  // result codes
  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_FAULT     = 3'd1;
  localparam logic [2:0] RES_VIOLATION = 3'd2;
  localparam logic [2:0] RES_LOADED    = 3'd3;
  localparam logic [2:0] RES_NOT_RES   = 3'd4;
  localparam logic [2:0] RES_IGNORED   = 3'd5;

  // configuration register indexes
  localparam logic CFG_FRAMES_IN_USE = 1'b0;
  localparam logic CFG_FRAME_SIZE    = 1'b1;

  localparam logic [3:0] SHIFT_MIN = 4'd4;
  localparam logic [3:0] SHIFT_MAX = 4'd12;
  localparam logic [2:0] MAX_LOADS = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  proc_id;
    logic [15:0] virt_address;
    logic [6:0]  access_bytes;
    logic [16:0] proc_mem_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic        last_of_run;
    logic [11:0] virt_page;
    logic [5:0]  frame_index;
    logic [11:0] page_offset;
    logic        evicted;
    logic [3:0]  evicted_proc;
    logic [11:0] evicted_page;
    logic [31:0] pages_in_total;
    logic [31:0] pages_out_total;
  } resp_t;

  typedef struct packed {
    logic [3:0]  owner;
    logic [11:0] page;
    logic [31:0] stamp;
  } frame_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_FINAL
  } state_t;

endpackage

### rtl/dpfm_frame_mem.sv
// ----------------------------------------------------------------------------
// dpfm_frame_mem
// Frame table memory: owner, page and load stamp per frame, one write and
// one registered read per cycle.
// ----------------------------------------------------------------------------
module dpfm_frame_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  dpfm_pkg::frame_entry_t wdata,
  input  logic [AW-1:0]         raddr,
  output dpfm_pkg::frame_entry_t rdata
);
  import dpfm_pkg::*;

  frame_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/demand_paging_frame_manager.sv
// One request is taken at a time (in_stall is high outside idle); access, translate
//   and release requests scan the frame table one entry per cycle, an access once per page.
// Reset (rst, synchronous): frame table empty, no process registered, load
//   clock and page totals zero, frames_in_use 0, frame_size_log2 4.
// ----------------------------------------------------------------------------
// demand_paging_frame_manager
// Frame table manager with demand paging and FIFO replacement.
// ----------------------------------------------------------------------------
module demand_paging_frame_manager #(
  parameter int NUM_FRAMES       = dpfm_pkg::NUM_FRAMES_DEF,
  parameter int NUM_PROCS        = dpfm_pkg::NUM_PROCS_DEF,
  parameter int VIRT_LIMIT_BYTES = dpfm_pkg::VIRT_LIMIT_BYTES_DEF,
  parameter int MAX_ACCESS_BYTES = dpfm_pkg::MAX_ACCESS_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dpfm_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dpfm_pkg::resp_t out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [6:0]      cfg_data
);
  import dpfm_pkg::*;

  localparam int FIW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int PIW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  // configuration
  logic [6:0] cfg_frames;
  logic [3:0] cfg_shift;

  // control state
  state_t                state, state_next;
  logic [NUM_FRAMES-1:0] used;        // frame valid bits; invalid entry reads as zero
  logic [NUM_PROCS-1:0]  registered;
  logic [31:0]           load_clock, pin, pout;

  // request context
  req_t        req_q;
  logic [11:0] vp_q, last_q;
  logic [2:0]  kcnt;
  logic        faulted;

  // scan pipeline: issue address, compare returned entry in the following cycle
  logic [FIW-1:0] scan_idx, cmp_idx;
  logic           cmp_vld;
  logic           hit_f, free_f;
  logic [FIW-1:0] hit_idx, free_idx, min_idx;
  logic [31:0]    min_stamp;
  logic [3:0]     min_owner;
  logic [11:0]    min_page;

  // final beat contents
  logic [2:0]  fin_code;
  logic [11:0] fin_vp, fin_off;
  logic [5:0]  fin_frame;

  frame_entry_t mem_rdata, mem_wdata, ent;
  logic         mem_we;
  logic [FIW-1:0] slot;

  logic [CW-1:0] n_act;
  logic [3:0]    sh;
  logic          accept, out_free;
  logic          load_now, adv, fin_emit, scan_last;
  logic          ent_used, ent_match, ent_own;
  logic          proc_ok, acc_viol, reg_ok;
  logic [PIW-1:0] pidx, qidx;
  logic [16:0]   end_sum, end_addr;
  logic [11:0]   first_vp, last_vp;
  logic [15:0]   off_mask;
  resp_t         load_resp, fin_resp;
  logic [31:0]   pin_next, pout_next, stamp_next;

  dpfm_frame_mem #(.DEPTH(NUM_FRAMES), .AW(FIW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .raddr (scan_idx),
    .rdata (mem_rdata)
  );

  // ---------------- decode of the offered request and table lookups --------
  always_comb begin
    n_act = (32'(cfg_frames) > NUM_FRAMES) ? CW'(NUM_FRAMES) : CW'(cfg_frames);
    if (cfg_shift < SHIFT_MIN) sh = SHIFT_MIN;
    else if (cfg_shift > SHIFT_MAX) sh = SHIFT_MAX;
    else sh = cfg_shift;

    pidx     = PIW'(in_data.proc_id);
    qidx     = PIW'(req_q.proc_id);
    proc_ok  = 32'(in_data.proc_id) < NUM_PROCS;
    reg_ok   = proc_ok && ((in_data.proc_mem_bytes >> sh) != 17'd0);
    end_sum  = 17'(in_data.virt_address) + 17'(in_data.access_bytes);
    end_addr = end_sum - 17'd1;
    acc_viol = !proc_ok || !registered[pidx] || (in_data.access_bytes == 7'd0) ||
               (32'(in_data.access_bytes) > MAX_ACCESS_BYTES) ||
               (32'(end_sum) > VIRT_LIMIT_BYTES);
    first_vp = 12'(in_data.virt_address >> sh);
    last_vp  = 12'(end_addr[15:0] >> sh);
    off_mask = (16'd1 << sh) - 16'd1;

    // entry coming back from the memory
    ent_used  = used[cmp_idx];
    ent       = ent_used ? mem_rdata : '0;
    ent_own   = ent_used && (ent.owner == req_q.proc_id);
    ent_match = ent_own && (ent.page == vp_q);

    slot       = free_f ? free_idx : min_idx;
    stamp_next = load_clock + 32'd1;
    pin_next   = pin + 32'd1;
    pout_next  = pout + (free_f ? 32'd0 : 32'd1);
    mem_wdata  = '{owner: req_q.proc_id, page: vp_q, stamp: stamp_next};
  end

  // ---------------- FSM outputs ------------------------------------------------
  always_comb begin
    in_stall  = (state != ST_IDLE);
    accept    = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    scan_last = (CW'(scan_idx) + CW'(1)) == n_act;
    load_now  = (state == ST_RESOLVE) && (req_q.req_type == REQ_ACCESS) && !hit_f &&
                (n_act != '0) && (kcnt < MAX_LOADS) && out_free;
    mem_we    = load_now;
    adv       = (state == ST_RESOLVE) && (req_q.req_type == REQ_ACCESS) &&
                (hit_f || load_now);
    fin_emit  = (state == ST_FINAL) && out_free;

    load_resp = '0;
    load_resp.result_code     = RES_LOADED;
    load_resp.virt_page       = vp_q;
    load_resp.frame_index     = 6'(slot);
    load_resp.evicted         = !free_f;
    load_resp.evicted_proc    = free_f ? 4'd0 : min_owner;
    load_resp.evicted_page    = free_f ? 12'd0 : min_page;
    load_resp.pages_in_total  = pin_next;
    load_resp.pages_out_total = pout_next;

    fin_resp = '0;
    fin_resp.result_code     = fin_code;
    fin_resp.last_of_run     = 1'b1;
    fin_resp.virt_page       = fin_vp;
    fin_resp.frame_index     = fin_frame;
    fin_resp.page_offset     = fin_off;
    fin_resp.pages_in_total  = pin;
    fin_resp.pages_out_total = pout;
  end

  // ---------------- FSM next state ---------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data.req_type == REQ_TRANSLATE) || (in_data.req_type == REQ_RELEASE) ||
              ((in_data.req_type == REQ_ACCESS) && !acc_viol)) begin
            state_next = (n_act == '0) ? ST_RESOLVE : ST_SCAN;
          end else begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_RESOLVE;
      ST_RESOLVE: begin
        if (req_q.req_type != REQ_ACCESS) begin
          state_next = ST_FINAL;
        end else if (adv) begin
          state_next = (vp_q == last_q) ? ST_FINAL : ST_SCAN;
        end else if ((n_act == '0) || (kcnt >= MAX_LOADS)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------- registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      used       <= '0;
      registered <= '0;
      load_clock <= '0;
      pin        <= '0;
      pout       <= '0;
      cfg_frames <= '0;
      cfg_shift  <= SHIFT_MIN;
      cmp_vld    <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == ST_SCAN);
      cmp_idx <= scan_idx;

      // a new beat (load or final) replaces the one leaving this cycle
      if (load_now || fin_emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      // config write clears the tables as well
      if (cfg_we) begin
        if (cfg_index == CFG_FRAMES_IN_USE) cfg_frames <= cfg_data;
        else cfg_shift <= cfg_data[3:0];
        used       <= '0;
        registered <= '0;
        load_clock <= '0;
      end

      if (state == ST_SCAN) scan_idx <= scan_idx + FIW'(1);

      if (accept) begin
        req_q     <= in_data;
        vp_q      <= first_vp;
        last_q    <= last_vp;
        kcnt      <= '0;
        faulted   <= 1'b0;
        scan_idx  <= '0;
        hit_f     <= 1'b0;
        free_f    <= 1'b0;
        fin_vp    <= '0;
        fin_frame <= '0;
        fin_off   <= '0;
        unique case (in_data.req_type)
          REQ_REGISTER: begin
            if (reg_ok) begin
              registered[pidx] <= 1'b1;
              fin_code         <= RES_OK;
            end else begin
              fin_code <= RES_IGNORED;
            end
          end
          REQ_ACCESS: fin_code <= acc_viol ? RES_VIOLATION : RES_OK;
          REQ_TRANSLATE, REQ_RELEASE: fin_code <= RES_OK;
          REQ_CLEAR: begin
            used       <= '0;
            registered <= '0;
            load_clock <= '0;
            fin_code   <= RES_OK;
          end
          default: fin_code <= RES_IGNORED;
        endcase
      end

      // compare stage of the scan
      if (cmp_vld) begin
        if (ent_match && !hit_f) begin
          hit_f   <= 1'b1;
          hit_idx <= cmp_idx;
        end
        if (!ent_used && !free_f) begin
          free_f   <= 1'b1;
          free_idx <= cmp_idx;
        end
        if ((cmp_idx == '0) || (ent.stamp < min_stamp)) begin
          min_stamp <= ent.stamp;
          min_idx   <= cmp_idx;
          min_owner <= ent.owner;
          min_page  <= ent.page;
        end
        if ((req_q.req_type == REQ_RELEASE) && ent_own) used[cmp_idx] <= 1'b0;
      end

      if (state == ST_RESOLVE) begin
        if (req_q.req_type == REQ_TRANSLATE) begin
          fin_code  <= hit_f ? RES_OK : RES_NOT_RES;
          fin_vp    <= vp_q;
          fin_frame <= hit_f ? 6'(hit_idx) : 6'd0;
          fin_off   <= hit_f ? 12'(req_q.virt_address & off_mask) : 12'd0;
        end else if (req_q.req_type == REQ_RELEASE) begin
          if (32'(req_q.proc_id) < NUM_PROCS) registered[qidx] <= 1'b0;
        end else if (!adv && ((n_act == '0) || (kcnt >= MAX_LOADS)) && !hit_f) begin
          fin_code <= RES_VIOLATION;
        end
      end

      // page load: write the frame and send the page-loaded beat
      if (load_now) begin
        used[slot] <= 1'b1;
        load_clock <= stamp_next;
        pin        <= pin_next;
        pout       <= pout_next;
        kcnt       <= kcnt + 3'd1;
        faulted    <= 1'b1;
        out_data   <= load_resp;
      end

      if (adv) begin
        if (vp_q == last_q) begin
          fin_code <= (faulted || load_now) ? RES_FAULT : RES_OK;
        end else begin
          vp_q     <= vp_q + 12'd1;
          scan_idx <= '0;
          hit_f    <= 1'b0;
          free_f   <= 1'b0;
        end
      end

      if (fin_emit) begin
        out_data <= fin_resp;
      end
    end
  end

  // ---------------- assertions -------------------------------------------------
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(scan_idx) < n_act))
    else $error("scan index beyond active frames");

  a_pin_step: assert property (@(posedge clk) disable iff (rst)
    ##1 ((pin == $past(pin)) || (pin == $past(pin) + 32'd1)))
    else $error("page-in count jumped");

  a_evict_on_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evicted) |-> (out_data.result_code == RES_LOADED))
    else $error("eviction flagged on a non-load beat");

  a_load_needs_frames: assert property (@(posedge clk) disable iff (rst)
    load_now |-> (n_act != '0) && (state == ST_RESOLVE))
    else $error("page load with no active frames");

endmodule
